// ===== hdl/bfks_pkg.sv =====
// ----------------------------------------------------------------------------
// bfks_pkg
// Shared types and codes for the bounded key queue with linear search.
// ----------------------------------------------------------------------------
package bfks_pkg;

    localparam int CNT_W = 5;
    localparam int POS_W = 4;
    localparam int OP_W  = 2;
    localparam int KEY_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
        logic             full_res;
    } t_res;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic scan_start;
        logic scan_step;
        logic finish;
        logic ok;
        logic take_pos;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            hit;
        logic            last;
    } t_sts;

endpackage

// ===== hdl/bounded_fifo_with_key_search_core.sv =====
// ----------------------------------------------------------------------------
// bounded_fifo_with_key_search_core
// Bounded FIFO of record keys with push, pop and head-first key search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the request's single result is presented. The result is valid for
// exactly one cycle with o_done and must be captured then. Push, pop and the
// no-op finish in the execute state, and o_done is registered from there. A
// search reads the key store one entry per cycle through its single
// registered read port, up to the hit or at most the held count of entries.
// Capacity must be written only while the block is idle; this is not enforced.
module bounded_fifo_with_key_search_core #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bfks_pkg::t_req             i_req,
    input  logic                       i_cfg_we,
    input  logic [bfks_pkg::CNT_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output bfks_pkg::t_res             o_res
);

    import bfks_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bfks_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bfks_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res)
    );

endmodule

// ===== hdl/bfks_ram.sv =====
// ----------------------------------------------------------------------------
// bfks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bfks_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfks_ctrl
// Request sequencer: decodes the operation and steps the search scan.
// ----------------------------------------------------------------------------
module bfks_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    input  bfks_pkg::t_sts i_sts,
    output bfks_pkg::t_cmd o_cmd
);

    import bfks_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_done;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && !r_busy) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    OP_PUSH: begin
                        cmd.push   = !i_sts.full;
                        cmd.ok     = !i_sts.full;
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                    OP_POP: begin
                        cmd.pop    = !i_sts.empty;
                        cmd.ok     = !i_sts.empty;
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                    OP_SEARCH: begin
                        if (i_sts.empty) begin
                            cmd.finish = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    cmd.finish   = 1'b1;
                    cmd.ok       = 1'b1;
                    cmd.take_pos = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.last) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= cmd.finish;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_cmd  = cmd;

endmodule

// ===== hdl/bfks_dp.sv =====
// ----------------------------------------------------------------------------
// bfks_dp
// Datapath: ring key store, head/tail pointers, count, capacity, scan compare.
// ----------------------------------------------------------------------------
module bfks_dp #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bfks_pkg::t_req         i_req,
    input  logic                   i_cfg_we,
    input  logic [bfks_pkg::CNT_W-1:0] i_cfg_wdata,
    input  bfks_pkg::t_cmd         i_cmd,
    output bfks_pkg::t_sts         o_sts,
    output bfks_pkg::t_res         o_res
);

    import bfks_pkg::*;

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STORE_W = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int CAP_LIM = (DEPTH < 31) ? DEPTH : 31;

    logic [OP_W-1:0]    r_op;
    logic [STORE_W-1:0] r_key;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [AW-1:0]      r_rd_slot;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_cmp_off;
    logic [CNT_W-1:0]   r_cap;
    t_res               r_res;

    logic [CNT_W-1:0]   eff_cap;
    logic [CNT_W-1:0]   n_count;
    logic [AW-1:0]      rd_addr;
    logic [STORE_W-1:0] rd_data;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign eff_cap = (r_cap > CNT_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : r_cap;
    assign rd_addr = i_cmd.scan_start ? r_head : r_rd_slot;

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    bfks_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_tail),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (i_cmd.pop) begin
                r_head <= ptr_inc(r_head);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req.opcode;
            r_key <= i_req.key[STORE_W-1:0];
        end
        if (i_cmd.scan_start) begin
            r_rd_slot <= ptr_inc(r_head);
            r_cmp_off <= '0;
        end else if (i_cmd.scan_step) begin
            r_rd_slot <= ptr_inc(r_rd_slot);
            r_cmp_off <= r_cmp_off + 1'b1;
        end
        if (i_cmd.finish) begin
            r_res.ok          <= i_cmd.ok;
            r_res.position    <= i_cmd.take_pos ? r_cmp_off[POS_W-1:0] : '0;
            r_res.entry_count <= n_count;
            r_res.full_res    <= (n_count >= eff_cap);
        end
    end

    assign o_sts.op    = r_op;
    assign o_sts.full  = (r_count >= eff_cap);
    assign o_sts.empty = (r_count == '0);
    assign o_sts.hit   = (rd_data == r_key);
    assign o_sts.last  = (r_cmp_off == r_count - 1'b1);
    assign o_res       = r_res;

endmodule
